[hw/rtl/universal_motor_plant_step_assert.svh]
// ---------------------------------------------------------------------------
// Motor plant assertion macros
// Shared property forms for the motor plant checks, clocked on clk with
// the synchronous active-low reset masking each check.
// ---------------------------------------------------------------------------
`ifndef UNIVERSAL_MOTOR_PLANT_STEP_ASSERT_SVH
`define UNIVERSAL_MOTOR_PLANT_STEP_ASSERT_SVH

// same-cycle implication
`define UMPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UMPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/umps_pkg.sv]
// ---------------------------------------------------------------------------
// Motor plant package
// Widths, register map, reset values and controller command types.
// ---------------------------------------------------------------------------
package umps_pkg;

  localparam int DRIVE_W  = 18;
  localparam int SPEED_W  = 24;
  localparam int EMF_W    = 20;
  localparam int TORQUE_W = 16;
  localparam int MAXSPD_W = 16;
  localparam int INV_W    = 32;
  localparam int ALPHA_W  = 16;
  localparam int SCALE_W  = 24;
  localparam int LOAD_W   = 32;
  localparam int VOLT_W   = 22;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 25;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int IDX_W    = 3;

  localparam logic [TORQUE_W-1:0] TORQUE_LIMIT  = 16'd25600;
  localparam logic [15:0]         LOAD_PER_UNIT = 16'd25600;

  localparam logic [TORQUE_W-1:0] LOAD_TORQUE_RST = 16'd0;
  localparam logic [MAXSPD_W-1:0] MAX_SPEED_RST   = 16'd3000;
  localparam logic [INV_W-1:0]    INV_MAX_RST     = 32'd1431656;
  localparam logic [ALPHA_W-1:0]  ALPHA_ELEC_RST  = 16'd55541;
  localparam logic [ALPHA_W-1:0]  ALPHA_MECH_RST  = 16'd16384;
  localparam logic [SCALE_W-1:0]  OUT_SCALE_RST   = 24'd27962;

  typedef enum logic [IDX_W-1:0] {
    REG_LOAD_TORQUE  = 3'd0,
    REG_MAX_SPEED    = 3'd1,
    REG_INV_MAX      = 3'd2,
    REG_ALPHA_ELEC   = 3'd3,
    REG_ALPHA_MECH   = 3'd4,
    REG_OUTPUT_SCALE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [TORQUE_W-1:0] load_torque;
    logic [MAXSPD_W-1:0] max_speed;
    logic [INV_W-1:0]    inv_max_speed;
    logic [ALPHA_W-1:0]  alpha_electrical;
    logic [ALPHA_W-1:0]  alpha_mechanical;
    logic [SCALE_W-1:0]  output_scale;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RAW,
    MUL_ELEC,
    MUL_MECH,
    MUL_EMF,
    MUL_MEAS
  } mul_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_RAW,
    WB_ELEC,
    WB_MECH,
    WB_EMF,
    WB_MEAS
  } wb_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    wb_op_t  wb_op;
    logic    load_in;
    logic    load_out;
  } cmd_t;

endpackage

[hw/rtl/umps_ctrl.sv]
// ---------------------------------------------------------------------------
// Motor plant controller
// Sequences one sample through the shared multiplier and write-back steps
// and owns the input and result handshakes.
// ---------------------------------------------------------------------------
module umps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output umps_pkg::cmd_t cmd
);
  import umps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_RAW,
    S_WB_RAW,
    S_MUL_ELEC,
    S_WB_ELEC,
    S_MUL_MECH,
    S_WB_MECH,
    S_MUL_EMF,
    S_WB_EMF,
    S_WB_MEAS,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '{mul_op: MUL_NONE, wb_op: WB_NONE, load_in: 1'b0, load_out: 1'b0};
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL_RAW;
        end
      end
      S_MUL_RAW: begin
        cmd.mul_op = MUL_RAW;
        state_nxt  = S_WB_RAW;
      end
      S_WB_RAW: begin
        cmd.wb_op = WB_RAW;
        state_nxt = S_MUL_ELEC;
      end
      S_MUL_ELEC: begin
        cmd.mul_op = MUL_ELEC;
        state_nxt  = S_WB_ELEC;
      end
      S_WB_ELEC: begin
        cmd.wb_op = WB_ELEC;
        state_nxt = S_MUL_MECH;
      end
      S_MUL_MECH: begin
        cmd.mul_op = MUL_MECH;
        state_nxt  = S_WB_MECH;
      end
      S_WB_MECH: begin
        cmd.wb_op = WB_MECH;
        state_nxt = S_MUL_EMF;
      end
      S_MUL_EMF: begin
        cmd.mul_op = MUL_EMF;
        state_nxt  = S_WB_EMF;
      end
      S_WB_EMF: begin
        cmd.wb_op  = WB_EMF;
        cmd.mul_op = MUL_MEAS;
        state_nxt  = S_WB_MEAS;
      end
      S_WB_MEAS: begin
        cmd.wb_op = WB_MEAS;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/umps_datapath.sv]
// ---------------------------------------------------------------------------
// Motor plant datapath
// Shared signed multiplier with registered product, the lag and back EMF
// state, and the result registers.
// ---------------------------------------------------------------------------
module umps_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  umps_pkg::cmd_t                   cmd,
  input  umps_pkg::cfg_t                   cfg,
  input  logic signed [umps_pkg::DRIVE_W-1:0] in_drive_voltage,
  output logic [umps_pkg::SPEED_W-1:0]     out_measurement,
  output logic [umps_pkg::SPEED_W-1:0]     out_reported_speed
);
  import umps_pkg::*;

  logic signed [DRIVE_W-1:0] drive_r;
  logic [LOAD_W-1:0]         load_r, load_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic [SPEED_W-1:0]        raw_r, raw_nxt;
  logic [SPEED_W-1:0]        elag_r, mlag_r;
  logic [EMF_W-1:0]          emf_r, emf_nxt;
  logic [SPEED_W-1:0]        meas_r, meas_nxt;
  logic [SPEED_W-1:0]        out_meas_r, out_rep_r;

  logic signed [VOLT_W-1:0]  volt;
  logic signed [MUL_B_W-1:0] diff_elec, diff_mech;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W:0]    net;
  logic [PROD_W-8:0]         net_shift;
  logic [PROD_W-25:0]        emf_full;
  logic [PROD_W-17:0]        meas_full;

  assign volt = $signed({{(VOLT_W-DRIVE_W){drive_r[DRIVE_W-1]}}, drive_r})
              - $signed({{(VOLT_W-EMF_W){1'b0}}, emf_r});
  assign diff_elec = $signed({1'b0, raw_r}) - $signed({1'b0, elag_r});
  assign diff_mech = $signed({1'b0, elag_r}) - $signed({1'b0, mlag_r});
  assign load_nxt  = LOAD_W'({1'b0, cfg.load_torque} + 17'd256) * LOAD_W'(LOAD_PER_UNIT);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_RAW: begin
        mul_a = $signed({{(MUL_A_W-MAXSPD_W){1'b0}}, cfg.max_speed});
        mul_b = $signed({{(MUL_B_W-VOLT_W){volt[VOLT_W-1]}}, volt});
      end
      MUL_ELEC: begin
        mul_a = $signed({{(MUL_A_W-ALPHA_W){1'b0}}, cfg.alpha_electrical});
        mul_b = diff_elec;
      end
      MUL_MECH: begin
        mul_a = $signed({{(MUL_A_W-ALPHA_W){1'b0}}, cfg.alpha_mechanical});
        mul_b = diff_mech;
      end
      MUL_EMF: begin
        mul_a = $signed({{(MUL_A_W-INV_W){1'b0}}, cfg.inv_max_speed});
        mul_b = $signed({1'b0, mlag_r});
      end
      MUL_MEAS: begin
        mul_a = $signed({{(MUL_A_W-SCALE_W){1'b0}}, cfg.output_scale});
        mul_b = $signed({1'b0, mlag_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // raw speed: clamp at zero, drop eight fraction bits, saturate
  assign net       = $signed({prod_r[PROD_W-1], prod_r}) - $signed({{(PROD_W+1-LOAD_W){1'b0}}, load_r});
  assign net_shift = net[PROD_W:8];
  always_comb begin
    if (net[PROD_W] || (net == '0)) begin
      raw_nxt = '0;
    end else if (|net_shift[PROD_W-8:SPEED_W]) begin
      raw_nxt = '1;
    end else begin
      raw_nxt = net_shift[SPEED_W-1:0];
    end
  end

  assign emf_full  = prod_r[PROD_W-1:24];
  assign emf_nxt   = (|emf_full[PROD_W-25:EMF_W]) ? '1 : emf_full[EMF_W-1:0];
  assign meas_full = prod_r[PROD_W-1:16];
  assign meas_nxt  = (|meas_full[PROD_W-17:SPEED_W]) ? '1 : meas_full[SPEED_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      drive_r <= in_drive_voltage;
      load_r  <= load_nxt;
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.wb_op == WB_RAW) begin
      raw_r <= raw_nxt;
    end
    if (cmd.wb_op == WB_MEAS) begin
      meas_r <= meas_nxt;
    end
    if (cmd.load_out) begin
      out_meas_r <= meas_r;
      out_rep_r  <= (cfg.load_torque > TORQUE_LIMIT) ? '0 : mlag_r;
    end
  end

  // plant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elag_r <= '0;
      mlag_r <= '0;
      emf_r  <= '0;
    end else begin
      case (cmd.wb_op)
        WB_ELEC: elag_r <= elag_r + prod_r[SPEED_W+15:16];
        WB_MECH: mlag_r <= mlag_r + prod_r[SPEED_W+15:16];
        WB_EMF:  emf_r  <= emf_nxt;
        default: ;
      endcase
    end
  end

  assign out_measurement    = out_meas_r;
  assign out_reported_speed = out_rep_r;

endmodule

[hw/rtl/universal_motor_plant_step.sv]
// ---------------------------------------------------------------------------
// Universal motor plant step
// Fixed-point motor plant model for hardware-in-the-loop rigs.
// ---------------------------------------------------------------------------
// Input channel: one drive voltage beat (signed Q2.16) per plant sample on
// in_valid/in_ready. Result channel: one beat per sample on
// out_valid/out_ready carrying the measurement (Q8.16) and the reported
// speed (Q16.8).
// A sample takes five multiplies in series through the one shared
// multiplier, each followed by a write-back step, and no new sample is
// taken until the current one has been loaded into the result register.
// The result register holds a finished beat while the next sample is
// worked on; if the receiver still stalls when that sample completes, the
// block waits and takes no new input until the register frees.
// Reset clears the lag and back EMF state, drops any pending beat and loads
// the registers with their defaults. Write registers over the APB port only
// while no sample is in flight.
// ---------------------------------------------------------------------------
module universal_motor_plant_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [umps_pkg::DRIVE_W-1:0] in_drive_voltage,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [umps_pkg::SPEED_W-1:0]        out_measurement,
  output logic [umps_pkg::SPEED_W-1:0]        out_reported_speed,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [umps_pkg::ADDR_W-1:0]         paddr,
  input  logic [umps_pkg::DATA_W-1:0]         pwdata,
  output logic [umps_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import umps_pkg::*;

  `include "universal_motor_plant_step_assert.svh"

  cfg_t     cfg_r;
  cmd_t     cmd;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.load_torque      <= LOAD_TORQUE_RST;
      cfg_r.max_speed        <= MAX_SPEED_RST;
      cfg_r.inv_max_speed    <= INV_MAX_RST;
      cfg_r.alpha_electrical <= ALPHA_ELEC_RST;
      cfg_r.alpha_mechanical <= ALPHA_MECH_RST;
      cfg_r.output_scale     <= OUT_SCALE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOAD_TORQUE:  cfg_r.load_torque      <= pwdata[TORQUE_W-1:0];
        REG_MAX_SPEED:    cfg_r.max_speed        <= pwdata[MAXSPD_W-1:0];
        REG_INV_MAX:      cfg_r.inv_max_speed    <= pwdata[INV_W-1:0];
        REG_ALPHA_ELEC:   cfg_r.alpha_electrical <= pwdata[ALPHA_W-1:0];
        REG_ALPHA_MECH:   cfg_r.alpha_mechanical <= pwdata[ALPHA_W-1:0];
        REG_OUTPUT_SCALE: cfg_r.output_scale     <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOAD_TORQUE:  prdata = DATA_W'(cfg_r.load_torque);
      REG_MAX_SPEED:    prdata = DATA_W'(cfg_r.max_speed);
      REG_INV_MAX:      prdata = DATA_W'(cfg_r.inv_max_speed);
      REG_ALPHA_ELEC:   prdata = DATA_W'(cfg_r.alpha_electrical);
      REG_ALPHA_MECH:   prdata = DATA_W'(cfg_r.alpha_mechanical);
      REG_OUTPUT_SCALE: prdata = DATA_W'(cfg_r.output_scale);
      default:          prdata = '0;
    endcase
  end

  umps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  umps_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg_r),
    .in_drive_voltage   (in_drive_voltage),
    .out_measurement    (out_measurement),
    .out_reported_speed (out_reported_speed)
  );

  `UMPS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")
  `UMPS_ASSERT_NEXT(a_result_after_load, cmd.load_out, out_valid, "loaded result not presented")
  `UMPS_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready, !cmd.load_out, "waiting beat overwritten")

endmodule

[bench/testbench.sv]
// ---------------------------------------------------------------------------
// Motor plant step testbench
// Drives drive-voltage beats into the plant and checks each result beat,
// measurement and reported speed, against an in-bench fixed-point plant
// model that tracks the register writes made over the APB port. A short
// table of directed beats and register writes comes first, then phases of
// held-level voltage sequences with noise under changing register settings.
// Both channels idle at random; one phase stalls the receiver for long
// enough to back the block up onto its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import umps_pkg::*;

  localparam logic [SPEED_W-1:0] SPEED_FULL = '1;
  localparam logic [EMF_W-1:0]   EMF_FULL   = '1;
  localparam logic [IDX_W-1:0]   UNMAPPED_LO = 3'd6;
  localparam logic [IDX_W-1:0]   UNMAPPED_HI = 3'd7;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 16;

  typedef struct packed {
    logic [SPEED_W-1:0] meas;
    logic [SPEED_W-1:0] speed;
  } plant_out_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [IDX_W-1:0]           idx;
    logic [DATA_W-1:0]          value;
    logic signed [DRIVE_W-1:0]  drive;
    logic                       known;
    logic [SPEED_W-1:0]         meas;
    logic [SPEED_W-1:0]         speed;
  } dir_row_t;

  localparam int DIR_ROWS = 35;
  localparam dir_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
    '{ROW_BEAT,  3'd0, 32'd0, 18'h20000, 1'b1, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h00000, 1'b1, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h00001, 1'b1, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h3FFFF, 1'b1, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h10000, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h20000, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_LOAD_TORQUE,  32'h0000FFFF, 18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_LOAD_TORQUE,  32'd25600,    18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_LOAD_TORQUE,  32'd25601,    18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_MAX_SPEED,    32'd0,        18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h20000, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_MAX_SPEED,    32'h0000FFFF, 18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_INV_MAX,      32'hFFFFFFFF, 18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_ALPHA_ELEC,   32'd0,        18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_ALPHA_MECH,   32'h0000FFFF, 18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_OUTPUT_SCALE, 32'h00FFFFFF, 18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_LOAD_TORQUE,  32'd0,        18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_ALPHA_ELEC,   32'h0000FFFF, 18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_ALPHA_MECH,   32'd0,        18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, REG_ALPHA_MECH,   32'h0000FFFF, 18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h00000, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, UNMAPPED_LO,      32'd0,        18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_WRITE, UNMAPPED_HI,      32'hFFFFFFFF, 18'h0, 1'b0, 24'd0, 24'd0},
    '{ROW_BEAT,  3'd0, 32'd0, 18'h1FFFF, 1'b0, 24'd0, 24'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DRIVE_W-1:0] in_drive_voltage = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SPEED_W-1:0] out_measurement;
  logic [SPEED_W-1:0] out_reported_speed;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // sideband for directed beats whose result is typed in
  logic       beat_known = 1'b0;
  plant_out_t beat_typed = '0;

  // plant model: register copies and lag state
  logic [TORQUE_W-1:0] torque_q88 = LOAD_TORQUE_RST;
  logic [MAXSPD_W-1:0] rated_rpm  = MAX_SPEED_RST;
  logic [INV_W-1:0]    rpm_recip  = INV_MAX_RST;
  logic [ALPHA_W-1:0]  lag_e_coef = ALPHA_ELEC_RST;
  logic [ALPHA_W-1:0]  lag_m_coef = ALPHA_MECH_RST;
  logic [SCALE_W-1:0]  meas_scale = OUT_SCALE_RST;
  logic [SPEED_W-1:0]  elec_speed = '0;
  logic [SPEED_W-1:0]  mech_speed = '0;
  logic [EMF_W-1:0]    emf_volts  = '0;

  plant_out_t pending_samples [$];
  int unsigned mismatch_count = 0;
  int unsigned hold_asks = 0;
  int unsigned holds_done = 0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;
  int unsigned ready_pick;

  universal_motor_plant_step DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_drive_voltage   (in_drive_voltage),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_measurement    (out_measurement),
    .out_reported_speed (out_reported_speed),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #4 clk = ~clk;

  function automatic logic [SPEED_W-1:0] lag_filter(input logic [SPEED_W-1:0] held,
                                                    input logic [SPEED_W-1:0] target,
                                                    input logic [ALPHA_W-1:0] coef);
    logic [63:0] acc;
    acc = 64'(held) * (64'd65536 - 64'(coef)) + 64'(target) * 64'(coef);
    return acc[SPEED_W+15:16];
  endfunction

  function automatic plant_out_t advance_plant(input logic signed [DRIVE_W-1:0] drive);
    longint net;
    longint torque_drop;
    longint prod;
    longint unsigned raw;
    longint unsigned acc;
    plant_out_t r;
    net = longint'(drive) - longint'(emf_volts);
    torque_drop = longint'(100) * (longint'(torque_q88) + 256) * 256;
    prod = longint'(rated_rpm) * net - torque_drop;
    if (prod <= 0) begin
      raw = 0;
    end else begin
      raw = prod >>> 8;
      if (raw > 64'(SPEED_FULL)) raw = 64'(SPEED_FULL);
    end
    elec_speed = lag_filter(elec_speed, raw[SPEED_W-1:0], lag_e_coef);
    mech_speed = lag_filter(mech_speed, elec_speed, lag_m_coef);
    acc = (64'(mech_speed) * 64'(rpm_recip)) >> 24;
    emf_volts = (acc > 64'(EMF_FULL)) ? EMF_FULL : acc[EMF_W-1:0];
    acc = (64'(mech_speed) * 64'(meas_scale)) >> 16;
    r.meas = (acc > 64'(SPEED_FULL)) ? SPEED_FULL : acc[SPEED_W-1:0];
    r.speed = (torque_q88 > TORQUE_LIMIT) ? '0 : mech_speed;
    return r;
  endfunction

  // model updates and result checks
  always @(posedge clk) begin : track_plant
    plant_out_t nxt;
    plant_out_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_LOAD_TORQUE:  torque_q88 = pwdata[TORQUE_W-1:0];
          REG_MAX_SPEED:    rated_rpm  = pwdata[MAXSPD_W-1:0];
          REG_INV_MAX:      rpm_recip  = pwdata[INV_W-1:0];
          REG_ALPHA_ELEC:   lag_e_coef = pwdata[ALPHA_W-1:0];
          REG_ALPHA_MECH:   lag_m_coef = pwdata[ALPHA_W-1:0];
          REG_OUTPUT_SCALE: meas_scale = pwdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        nxt = advance_plant(in_drive_voltage);
        if (beat_known) nxt = beat_typed;
        pending_samples.push_back(nxt);
      end
      if (out_valid && out_ready) begin
        if (pending_samples.size() == 0) begin
          $error("result beat with no sample pending: measurement %0d, reported_speed %0d",
                 out_measurement, out_reported_speed);
          mismatch_count++;
        end else begin
          want = pending_samples.pop_front();
          if (out_measurement !== want.meas) begin
            $error("measurement: expected %0d, actual %0d", want.meas, out_measurement);
            mismatch_count++;
          end
          if (out_reported_speed !== want.speed) begin
            $error("reported_speed: expected %0d, actual %0d", want.speed,
                   out_reported_speed);
            mismatch_count++;
          end
        end
      end
    end
  end

  // receiver: short random stalls, free-running stretches, long hold on request
  always @(posedge clk) begin
    if (holds_done != hold_asks) begin
      holds_done = hold_asks;
      stall_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (free_left > 0) begin
      free_left--;
      out_ready <= 1'b1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 55) begin
        out_ready <= 1'b1;
      end else if (ready_pick < 85) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else if (ready_pick < 93) begin
        stall_left = $urandom_range(8, 40);
        out_ready <= 1'b0;
      end else begin
        free_left = $urandom_range(30, 120);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer_drive(input logic signed [DRIVE_W-1:0] v, input logic known,
                             input plant_out_t typed, input int gap);
    in_valid <= 1'b1;
    in_drive_voltage <= v;
    beat_known <= known;
    beat_typed <= typed;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, wait for every pending result, then let the pipe settle
  task automatic drain_plant();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t row;
    plant_out_t typed;
    logic [DATA_W-1:0] cfg_vals [0:5];
    logic signed [DRIVE_W-1:0] drive;
    int unsigned rated;
    int run_left;
    int level;
    int lvl;
    bit noisy;
    bit burst;
    run_left = 0;
    level = 0;
    noisy = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_WRITE) begin
        drain_plant();
        write_reg(int'(row.idx), row.value);
      end else begin
        typed.meas = row.meas;
        typed.speed = row.speed;
        offer_drive(row.drive, row.known, typed, pick_gap());
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          cfg_vals = '{32'(LOAD_TORQUE_RST), 32'(MAX_SPEED_RST), 32'(INV_MAX_RST),
                       32'(ALPHA_ELEC_RST), 32'(ALPHA_MECH_RST), 32'(OUT_SCALE_RST)};
        end
        1: begin
          cfg_vals = '{32'hFFFF, 32'hFFFF, 32'hFFFFFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFFFF};
        end
        2: begin
          cfg_vals = '{32'd0, 32'd1, 32'd0, 32'hFFFF, 32'hFFFF, 32'd0};
        end
        default: begin
          rated = ($urandom_range(0, 99) < 70) ? $urandom_range(200, 12000)
                                               : $urandom_range(1, 65535);
          cfg_vals[REG_MAX_SPEED] = rated;
          if ($urandom_range(0, 99) < 80 && rated > 1)
            cfg_vals[REG_INV_MAX] = 32'(64'h1_0000_0000 / rated);
          else
            cfg_vals[REG_INV_MAX] = $urandom();
          case ($urandom_range(0, 19))
            0, 1, 2:    cfg_vals[REG_LOAD_TORQUE] = $urandom_range(25601, 65535);
            3, 4, 5, 6: cfg_vals[REG_LOAD_TORQUE] = $urandom_range(2049, 25600);
            default:    cfg_vals[REG_LOAD_TORQUE] = $urandom_range(0, 2048);
          endcase
          cfg_vals[REG_ALPHA_ELEC] = $urandom_range(0, 65535);
          cfg_vals[REG_ALPHA_MECH] = $urandom_range(0, 65535);
          cfg_vals[REG_OUTPUT_SCALE] = ($urandom_range(0, 99) < 70)
                                       ? $urandom_range(0, 200000)
                                       : ($urandom() & 32'hFFFFFF);
        end
      endcase
      drain_plant();
      for (int i = 0; i < 6; i++) write_reg(i, cfg_vals[i]);

      // pressure phases: beats come back to back; in one the receiver is also held off
      burst = (ph == 3) || (ph == 6);
      if (ph == 3) hold_asks++;

      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 5 && n == PHASE_BEATS / 2) drain_plant();
        if (run_left == 0) begin
          noisy = ($urandom_range(0, 99) < 15);
          run_left = noisy ? $urandom_range(1, 4) : $urandom_range(5, 30);
          if ($urandom_range(0, 99) < 20)
            level = int'($urandom_range(0, 262143)) - 131072;
          else
            level = int'($urandom_range(0, 131071));
        end
        run_left--;
        if (noisy) begin
          drive = DRIVE_W'($urandom());
        end else begin
          lvl = level + int'($urandom_range(0, 64)) - 32;
          if (lvl > 131071) lvl = 131071;
          if (lvl < -131072) lvl = -131072;
          drive = DRIVE_W'(lvl);
        end
        offer_drive(drive, 1'b0, '0, burst ? 0 : pick_gap());
      end
    end

    drain_plant();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/umps_pkg.sv
hw/rtl/umps_ctrl.sv
hw/rtl/umps_datapath.sv
hw/rtl/universal_motor_plant_step.sv
bench/testbench.sv
